@@ src/cet_pkg.sv @@
// Shared types and constants for the compacting entry table.
// Used by cet_ctrl, cet_datapath and compacting_entry_table_core.
package cet_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // wide enough for the count, the 8-bit slot and the 9-bit result fields
  localparam int WIDE_W   = (CNT_W > 9) ? CNT_W : 9;

  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_MARK    = 3'd1;
  localparam logic [2:0] MODE_DESTROY = 3'd2;
  localparam logic [2:0] MODE_SWEEP   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;

  localparam logic [7:0] KIND_INVALID = 8'h00;
  localparam logic [7:0] KIND_DEAD    = 8'h80;
  localparam logic [7:0] KIND_DEFAULT = 8'h7F;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  slot;
    logic [55:0] payload_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_out;
    logic [7:0]  entry_kind;
    logic [55:0] payload_out;
    logic [8:0]  live_count;
    logic [8:0]  free_space;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [55:0] payload;
  } entry_t;

  typedef enum logic [1:0] {RD_SLOT, RD_LAST, RD_IDX} rd_sel_t;
  typedef enum logic [1:0] {WR_CREATE, WR_MARK, WR_MOVE_SLOT, WR_MOVE_IDX} wr_sel_t;
  typedef enum logic [1:0] {KS_ZERO, KS_DEFAULT, KS_READ, KS_MARKED} kind_sel_t;

  typedef struct packed {
    logic       cap_req;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       idx_clr;
    logic       idx_inc;
    logic       res_load;
    logic [1:0] res_status;
    kind_sel_t  res_kind;
    logic       res_slot_cnt;
    logic       res_pay;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       slot_live;
    logic       slot_last;
    logic       idx_live;
    logic       idx_last;
    logic       rd_dead;
    logic       out_room;
  } stat_t;

endpackage

@@ src/cet_ctrl.sv @@
// Sequencer for the compacting entry table: decodes a request and steps
// the datapath through lookups, moves and the sweep walk. Needs cet_pkg.
module cet_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cet_pkg::stat_t stat,
  output cet_pkg::cmd_t  cmd
);
  import cet_pkg::*;

  typedef enum logic [2:0] {
    IDLE, DISPATCH, LOOKUP, MOVE_WR, SWEEP_RD, SWEEP_CHK, SWEEP_MOVE, FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no request is taken while reset is held
  assign req_stall = rst || (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.cap_req = 1'b1;
          state_next  = DISPATCH;
        end
      end
      DISPATCH: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_kind   = KS_ZERO;
        state_next     = FINISH;
        case (stat.mode)
          MODE_CREATE: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_en        = 1'b1;
              cmd.wr_sel       = WR_CREATE;
              cmd.cnt_inc      = 1'b1;
              cmd.res_kind     = KS_DEFAULT;
              cmd.res_slot_cnt = 1'b1;
            end
          end
          MODE_MARK, MODE_DESTROY, MODE_READ: begin
            if (!stat.slot_live) begin
              cmd.res_status = ST_NOT_LIVE;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_SLOT;
              state_next   = LOOKUP;
            end
          end
          MODE_SWEEP: begin
            cmd.idx_clr = 1'b1;
            state_next  = SWEEP_RD;
          end
          default: ;
        endcase
      end
      LOOKUP: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_kind   = KS_READ;
        state_next     = FINISH;
        case (stat.mode)
          MODE_MARK: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_MARK;
            cmd.res_kind = KS_MARKED;
          end
          MODE_READ: begin
            cmd.res_pay = 1'b1;
          end
          default: begin
            // destroy: kind is captured before the last entry moves in
            if (stat.slot_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = MOVE_WR;
            end
          end
        endcase
      end
      MOVE_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE_SLOT;
        cmd.cnt_dec = 1'b1;
        state_next  = FINISH;
      end
      SWEEP_RD: begin
        if (stat.idx_live) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = SWEEP_CHK;
        end else begin
          state_next = FINISH;
        end
      end
      SWEEP_CHK: begin
        if (!stat.rd_dead) begin
          cmd.idx_inc = 1'b1;
          state_next  = SWEEP_RD;
        end else if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = SWEEP_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          state_next = SWEEP_MOVE;
        end
      end
      SWEEP_MOVE: begin
        // slot is re-read on the next pass, so the moved entry gets checked
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE_IDX;
        cmd.cnt_dec = 1'b1;
        state_next  = SWEEP_RD;
      end
      FINISH: begin
        if (stat.out_room) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted but sequencer not busy");

  a_count_one_way: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count incremented and decremented together");

  a_load_with_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_room)
    else $error("result loaded over an unread result");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("table read and written in one cycle");

endmodule

@@ src/cet_datapath.sv @@
// Entry table storage, live count, sweep pointer and result registers.
// Driven by cet_ctrl through cmd_t; reports back through stat_t. Needs cet_pkg.
module cet_datapath (
  input  logic           clk,
  input  logic           rst,
  input  cet_pkg::req_t  req,
  input  cet_pkg::cmd_t  cmd,
  output cet_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cet_pkg::rsp_t  rsp
);
  import cet_pkg::*;

  entry_t mem [CAPACITY];

  req_t             req_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  entry_t           rd_data;
  logic [1:0]       res_status;
  logic [7:0]       res_slot;
  logic [7:0]       res_kind;
  logic [55:0]      res_payload;

  logic [CNT_W-1:0]  last;
  logic [WIDE_W-1:0] slot_wide;
  logic [WIDE_W-1:0] count_wide;
  logic [WIDE_W-1:0] free_wide;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;

  assign last       = count - CNT_W'(1);
  assign slot_wide  = WIDE_W'(req_q.slot);
  assign count_wide = WIDE_W'(count);
  assign free_wide  = WIDE_W'(CNT_W'(CAPACITY) - count);
  // only used once the slot is known to be live, so it fits the index
  assign slot_idx   = slot_wide[IDX_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_SLOT: raddr = slot_idx;
      RD_LAST: raddr = last[IDX_W-1:0];
      default: raddr = idx[IDX_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_CREATE: begin
        waddr = count[IDX_W-1:0];
        wdata = '{kind: KIND_DEFAULT, payload: req_q.payload_in};
      end
      WR_MARK: begin
        waddr = slot_idx;
        wdata = '{kind: rd_data.kind | KIND_DEAD, payload: rd_data.payload};
      end
      WR_MOVE_SLOT: begin
        waddr = slot_idx;
        wdata = rd_data;
      end
      default: begin
        waddr = idx[IDX_W-1:0];
        wdata = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_q <= req;
    end
    if (cmd.res_load) begin
      res_status  <= cmd.res_status;
      res_slot    <= cmd.res_slot_cnt ? count_wide[7:0] : req_q.slot;
      res_payload <= cmd.res_pay ? rd_data.payload : '0;
      case (cmd.res_kind)
        KS_DEFAULT: res_kind <= KIND_DEFAULT;
        KS_READ:    res_kind <= rd_data.kind;
        KS_MARKED:  res_kind <= rd_data.kind | KIND_DEAD;
        default:    res_kind <= KIND_INVALID;
      endcase
    end
    if (cmd.out_load) begin
      rsp <= '{status: res_status, slot_out: res_slot, entry_kind: res_kind,
               payload_out: res_payload, live_count: count_wide[8:0],
               free_space: free_wide[8:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= last;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.mode      = req_q.mode;
    stat.full      = (count == CNT_W'(CAPACITY));
    stat.slot_live = (slot_wide < count_wide);
    stat.slot_last = (slot_wide == WIDE_W'(last));
    stat.idx_live  = (idx < count);
    stat.idx_last  = (idx == last);
    stat.rd_dead   = ((rd_data.kind & KIND_DEAD) != KIND_INVALID);
    stat.out_room  = !rsp_valid || !rsp_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0)
    else $error("remove from an empty table");

  a_count_free_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 9'(rsp.live_count + rsp.free_space) == 9'(CAPACITY))
    else $error("live count and free space disagree");

endmodule

@@ src/compacting_entry_table_core.sv @@
// Compacting entry table: live entries stay packed from slot 0; create
// appends, destroy and sweep fill holes with the last entry. Create, a full
// create, unused modes and requests on a slot that is not live go from
// dispatch to the result; mark and read add a table lookup, destroy a
// lookup and, unless the slot is last, a move of the last entry; all set by
// the single table port (one read or one write per cycle, read registered).
// A sweep walks the live entries, dropping each marked one as destroy does.
// The next request is taken the cycle after its result is loaded; a loaded
// result waits in the output register. No clearing pass after reset: only
// live entries are ever read. Needs cet_pkg, cet_ctrl, cet_datapath.
module compacting_entry_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cet_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cet_pkg::rsp_t rsp
);
  import cet_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cet_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ dv/compacting_entry_table_core_test.sv @@
// Testbench for compacting_entry_table_core: drives table requests, predicts
// every response from a local copy of the table and checks it field by field.
// Depends on cet_pkg and the compacting_entry_table_core RTL.
module compacting_entry_table_core_test;
  import cet_pkg::*;

  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [7:0] SLOT_TOP         = 8'hFF;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // predicted table contents
  logic [7:0]  kind_tbl [CAPACITY];
  logic [55:0] pay_tbl  [CAPACITY];
  int unsigned live_n;

  rsp_t table_results_due [$];
  int   err_count;
  int   send_idle_pct;
  int   rsp_stall_pct;
  int   hold_len;
  logic hold_on = 1'b0;
  event hold_go;

  compacting_entry_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void drop_entry(int unsigned s);
    int unsigned last;
    last = live_n - 1;
    if (s != last) begin
      kind_tbl[s] = kind_tbl[last];
      pay_tbl[s]  = pay_tbl[last];
    end
    kind_tbl[last] = KIND_INVALID;
    live_n = last;
  endfunction

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t        o;
    int unsigned i;
    o          = '0;
    o.status   = ST_OK;
    o.slot_out = r.slot;
    case (r.mode)
      MODE_CREATE: begin
        if (live_n >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          o.slot_out       = 8'(live_n);
          kind_tbl[live_n] = KIND_DEFAULT;
          pay_tbl[live_n]  = r.payload_in;
          o.entry_kind     = KIND_DEFAULT;
          live_n++;
        end
      end
      MODE_MARK: begin
        if (r.slot >= live_n) begin
          o.status = ST_NOT_LIVE;
        end else begin
          kind_tbl[r.slot] = kind_tbl[r.slot] | KIND_DEAD;
          o.entry_kind     = kind_tbl[r.slot];
        end
      end
      MODE_DESTROY: begin
        if (r.slot >= live_n) begin
          o.status = ST_NOT_LIVE;
        end else begin
          o.entry_kind = kind_tbl[r.slot];
          drop_entry(r.slot);
        end
      end
      MODE_SWEEP: begin
        // a refilled slot is examined again before moving on
        i = 0;
        while (i < live_n) begin
          if ((kind_tbl[i] & KIND_DEAD) != 8'h00) drop_entry(i);
          else i++;
        end
      end
      MODE_READ: begin
        if (r.slot >= live_n) begin
          o.status = ST_NOT_LIVE;
        end else begin
          o.entry_kind  = kind_tbl[r.slot];
          o.payload_out = pay_tbl[r.slot];
        end
      end
      default: ;
    endcase
    o.live_count = 9'(live_n);
    o.free_space = 9'(CAPACITY - live_n);
    return o;
  endfunction

  // ------------------------------------------------------------ request side

  task automatic send_request(input logic [2:0] mode, input logic [7:0] slot,
                              input logic [55:0] payload);
    req_t r;
    r.mode       = mode;
    r.slot       = slot;
    r.payload_in = payload;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(negedge clk);
    while (req_stall) @(negedge clk);
    @(posedge clk);
    table_results_due.push_back(apply_table_op(r));
  endtask

  function automatic logic [55:0] rand_payload();
    return 56'({$urandom, $urandom});
  endfunction

  // ----------------------------------------------------------- response side

  always @(posedge clk) begin
    if (hold_on) rsp_stall <= 1'b1;
    else rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  // long output hold-off, counted here in cycles
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (hold_len) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic report_failure(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (table_results_due.size() == 0) begin
      report_failure($sformatf("response with none outstanding: %h", got));
      return;
    end
    want = table_results_due.pop_front();
    if (got.status !== want.status)
      report_failure($sformatf("status want %0d got %0d", want.status, got.status));
    if (got.slot_out !== want.slot_out)
      report_failure($sformatf("slot_out want %0d got %0d", want.slot_out, got.slot_out));
    if (got.entry_kind !== want.entry_kind)
      report_failure($sformatf("entry_kind want %h got %h", want.entry_kind,
                               got.entry_kind));
    if (got.payload_out !== want.payload_out)
      report_failure($sformatf("payload_out want %h got %h", want.payload_out,
                               got.payload_out));
    if (got.live_count !== want.live_count)
      report_failure($sformatf("live_count want %0d got %0d", want.live_count,
                               got.live_count));
    if (got.free_space !== want.free_space)
      report_failure($sformatf("free_space want %0d got %0d", want.free_space,
                               got.free_space));
  endtask

  // outputs are stable at the falling edge; a response seen here is taken next edge
  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_response(rsp);
  end

  // ------------------------------------------------------------------ tests

  task automatic run_reset();
    int k;
    for (k = 0; k < CAPACITY; k++) begin
      kind_tbl[k] = KIND_INVALID;
      pay_tbl[k]  = '0;
    end
    live_n    = 0;
    err_count = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_directed_ops();
    logic [2:0] m;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    // empty table: every slot-addressed request is rejected
    send_request(MODE_READ, 8'd0, '0);
    send_request(MODE_MARK, 8'd0, '0);
    send_request(MODE_DESTROY, 8'd0, '0);
    send_request(MODE_SWEEP, 8'd0, '0);
    send_request(MODE_CREATE, SLOT_TOP, 56'h0);
    send_request(MODE_CREATE, 8'd0, 56'hFF_FFFF_FFFF_FFFF);
    send_request(MODE_CREATE, 8'd0, 56'hAA_AAAA_AAAA_AAAA);
    send_request(MODE_CREATE, 8'd0, 56'h55_5555_5555_5555);
    send_request(MODE_CREATE, 8'd0, 56'h12_3456_789A_BCDE);
    send_request(MODE_READ, 8'd0, '0);
    send_request(MODE_READ, 8'd1, '0);
    send_request(MODE_READ, 8'd4, '0);
    send_request(MODE_READ, SLOT_TOP, '0);
    send_request(MODE_READ, 8'd5, '0);       // first slot past the live range
    send_request(MODE_MARK, 8'd1, '0);
    send_request(MODE_MARK, 8'd1, '0);       // stays marked
    send_request(MODE_READ, 8'd1, '0);
    send_request(MODE_DESTROY, 8'd4, '0);    // last entry, nothing moves
    send_request(MODE_DESTROY, 8'd0, '0);    // last entry moves into slot 0
    send_request(MODE_READ, 8'd0, '0);
    // marked entry refilled by a marked last entry: slot must be checked twice
    send_request(MODE_MARK, 8'd2, '0);
    send_request(MODE_SWEEP, 8'd7, '0);
    send_request(MODE_READ, 8'd0, '0);
    for (m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST && m >= MODE_SPARE_FIRST; m++)
      send_request(m, SLOT_TOP, rand_payload());
    send_request(MODE_DESTROY, 8'd0, '0);
  endtask

  task automatic test_fill_to_capacity();
    int k;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    while (live_n < CAPACITY)
      send_request(MODE_CREATE, 8'($urandom), rand_payload());
    send_request(MODE_CREATE, 8'($urandom), rand_payload());   // table full
    send_request(MODE_READ, SLOT_TOP, '0);
    send_request(MODE_MARK, SLOT_TOP, '0);
    send_request(MODE_MARK, SLOT_TOP - 8'd1, '0);
    for (k = 0; k < 60; k++)
      send_request(MODE_MARK, 8'($urandom_range(CAPACITY - 1)), '0);
    send_request(MODE_SWEEP, 8'($urandom), '0);
    send_request(MODE_READ, 8'd0, '0);
  endtask

  task automatic test_output_hold();
    int k;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_len = 150;
    -> hold_go;
    // sender keeps offering while responses are held back
    for (k = 0; k < 20; k++) begin
      if (k % 2 == 0) send_request(MODE_CREATE, 8'($urandom), rand_payload());
      else send_request(MODE_READ, 8'($urandom_range(live_n)), '0);
    end
  endtask

  task automatic test_random_ops(input int n, input int idle_pct, input int stall_pct);
    int         k;
    int         sel;
    int         create_w;
    logic [2:0] m;
    logic [7:0] s;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (k = 0; k < n; k++) begin
      // keep the table size wandering instead of pinned at empty or full
      create_w = (live_n > 160) ? 15 : (live_n < 8) ? 50 : 30;
      sel = $urandom_range(99);
      if (sel < create_w) m = MODE_CREATE;
      else if (sel < create_w + 15) m = MODE_MARK;
      else if (sel < create_w + 30) m = MODE_DESTROY;
      else if (sel < create_w + 33) m = MODE_SWEEP;
      else if (sel < create_w + 36) m = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      else m = MODE_READ;
      if (live_n > 0 && $urandom_range(99) < 85) s = 8'($urandom_range(live_n - 1));
      else s = 8'($urandom);
      send_request(m, s, rand_payload());
    end
  endtask

  task automatic finish_run();
    int waited;
    req_valid <= 1'b0;
    waited = 0;
    while (table_results_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (table_results_due.size() != 0)
      report_failure($sformatf("%0d responses never arrived", table_results_due.size()));
  endtask

  initial begin
    run_reset();
    test_directed_ops();
    test_fill_to_capacity();
    test_output_hold();
    test_random_ops(60, 0, 0);
    test_random_ops(60, 72, 0);
    test_random_ops(60, 0, 72);
    test_random_ops(60, 32, 32);
    finish_run();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
